// ===== hw/rtl/vlou_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlou_pkg
// Shared constants and types of the voxel log-odds update unit.
// ----------------------------------------------------------------------------
package vlou_pkg;

  localparam int unsigned GRID_X     = 128;
  localparam int unsigned GRID_Y     = 128;
  localparam int unsigned GRID_Z     = 32;
  localparam int unsigned LIST_DEPTH = 64;

  localparam int unsigned CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned LIST_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);

  localparam int unsigned VAL_W = 12;
  localparam int unsigned OBS_W = 8;

  localparam logic signed [VAL_W-1:0] UNKNOWN_VALUE = -12'sd513;
  localparam logic [OBS_W-1:0]        COUNT_MAX     = '1;

  localparam logic [1:0] REG_HIT_INC   = 2'd0;
  localparam logic [1:0] REG_MISS_INC  = 2'd1;
  localparam logic [1:0] REG_LOWER     = 2'd2;
  localparam logic [1:0] REG_UPPER     = 2'd3;

  localparam logic MODE_OBSERVE = 1'b0;
  localparam logic MODE_END_RAY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OBS,
    ST_WALK_RD,
    ST_WALK_CELL,
    ST_WALK_OUT
  } state_e;

endpackage

// ===== hw/rtl/voxel_log_odds_update_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_log_odds_update_unit
// Log-odds occupancy grid with per-ray hit/miss counting and clamped update.
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata {is_hit,z,y,x}, tuser mode
// m_axis    out  tvalid/tready    tdata {new_log_odds,voxel_address}, tuser
//                                 {dropped}, tlast last
// cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// Observe: read counters, then write back, through the one-port grid RAM.
// End of ray: per queued voxel a list read, a cell read and a write/emit step,
// which stalls while a result waits on m_axis_tready.
// After reset a clearing pass writes all CELLS = 524288 grid entries, one per
// cycle, with s_axis_tready low.
// ----------------------------------------------------------------------------
module voxel_log_odds_update_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // x[6:0], y[13:7], z[18:14], is_hit[19]
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // voxel_address[18:0], new_log_odds[30:19]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // dropped
);

  localparam int unsigned AW = vlou_pkg::ADDR_W;
  localparam int unsigned VW = vlou_pkg::VAL_W;
  localparam int unsigned OW = vlou_pkg::OBS_W;
  localparam int unsigned EW = VW + 2 * OW;

  // Grid RAM entry: {value, total, hits}
  logic [EW-1:0] grid_mem [vlou_pkg::CELLS];
  logic [AW-1:0] list_mem [vlou_pkg::LIST_DEPTH];

  logic signed [VW-1:0] hit_inc_q, miss_inc_q, lower_q, upper_q;

  vlou_pkg::state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [vlou_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [vlou_pkg::LIST_W-1:0] walk_q, walk_d;
  logic drop_q, drop_d;
  logic [AW-1:0] addr_q, addr_d;
  logic hit_q, hit_d;

  logic          g_we;
  logic [AW-1:0] g_addr;
  logic [EW-1:0] g_wdata, g_rdata_q;
  logic          l_we;
  logic [AW-1:0] l_rdata_q;

  logic          ov_q, ov_d;
  logic [AW-1:0] o_addr_q, o_addr_d;
  logic [VW-1:0] o_val_q, o_val_d;
  logic          o_last_q, o_last_d, o_drop_q, o_drop_d;

  always_ff @(posedge clk_i) begin
    if (g_we) grid_mem[g_addr] <= g_wdata;
    g_rdata_q <= grid_mem[g_addr];
    if (l_we) list_mem[cnt_q[vlou_pkg::LIST_W-1:0]] <= addr_q;
    l_rdata_q <= list_mem[walk_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_inc_q  <= 12'sd158;
      miss_inc_q <= -12'sd158;
      lower_q    <= -12'sd510;
      upper_q    <= 12'sd562;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vlou_pkg::REG_HIT_INC:  hit_inc_q  <= cfg_data_i;
        vlou_pkg::REG_MISS_INC: miss_inc_q <= cfg_data_i;
        vlou_pkg::REG_LOWER:    lower_q    <= cfg_data_i;
        vlou_pkg::REG_UPPER:    upper_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vlou_pkg::ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      walk_q  <= '0;
      drop_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      walk_q  <= walk_d;
      drop_q  <= drop_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    hit_q    <= hit_d;
    o_addr_q <= o_addr_d;
    o_val_q  <= o_val_d;
    o_last_q <= o_last_d;
    o_drop_q <= o_drop_d;
  end

  logic [6:0] in_x, in_y;
  logic [4:0] in_z;
  logic       in_out;
  logic [AW-1:0] in_addr;
  assign in_x = s_axis_tdata[6:0];
  assign in_y = s_axis_tdata[13:7];
  assign in_z = s_axis_tdata[18:14];
  assign in_out = (32'(in_x) >= vlou_pkg::GRID_X) || (32'(in_y) >= vlou_pkg::GRID_Y)
               || (32'(in_z) >= vlou_pkg::GRID_Z);
  assign in_addr = AW'(32'(in_x) * (vlou_pkg::GRID_Y * vlou_pkg::GRID_Z)
                 + 32'(in_y) * vlou_pkg::GRID_Z + 32'(in_z));

  logic signed [VW-1:0] r_val, inc, nv;
  logic [OW-1:0] r_tot, r_hit, n_tot, n_hit;
  logic signed [VW:0] sum;
  assign r_val = g_rdata_q[EW-1 -: VW];
  assign r_tot = g_rdata_q[2*OW-1 -: OW];
  assign r_hit = g_rdata_q[OW-1:0];
  assign inc = ({1'b0, r_tot} >= {r_hit, 1'b0}) ? miss_inc_q : hit_inc_q;
  assign sum = (VW+1)'(r_val) + (VW+1)'(inc);

  always_comb begin
    if (!inc[VW-1] && r_val >= upper_q) nv = r_val;
    else if ((inc[VW-1] || inc == '0) && r_val <= lower_q) nv = lower_q;
    else if (sum < (VW+1)'(lower_q)) begin
      nv = (lower_q > upper_q) ? upper_q : lower_q;
    end else if (sum > (VW+1)'(upper_q)) nv = upper_q;
    else nv = VW'(sum);
  end

  assign n_tot = (r_tot == vlou_pkg::COUNT_MAX) ? r_tot : r_tot + 1'b1;
  assign n_hit = (hit_q && r_hit != vlou_pkg::COUNT_MAX) ? r_hit + 1'b1 : r_hit;

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == vlou_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q; cnt_d = cnt_q; walk_d = walk_q; drop_d = drop_q;
    addr_d = addr_q; hit_d = hit_q;
    g_we = 1'b0; g_addr = addr_q; g_wdata = {r_val, n_tot, n_hit};
    l_we = 1'b0;
    ov_d = ov_q && !m_axis_tready;
    o_addr_d = o_addr_q; o_val_d = o_val_q; o_last_d = o_last_q; o_drop_d = o_drop_q;
    unique case (state_q)
      vlou_pkg::ST_CLEAR: begin
        g_we = 1'b1; g_addr = clr_q;
        g_wdata = {vlou_pkg::UNKNOWN_VALUE, {2*OW{1'b0}}};
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == vlou_pkg::CELLS - 1) state_d = vlou_pkg::ST_IDLE;
      end
      vlou_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == vlou_pkg::MODE_END_RAY) begin
            walk_d = '0;
            if (cnt_q == '0) drop_d = 1'b0;
            else state_d = vlou_pkg::ST_WALK_RD;
          end else if (in_out) begin
            drop_d = 1'b1;
          end else begin
            addr_d = in_addr; hit_d = s_axis_tdata[19];
            g_addr = in_addr;
            state_d = vlou_pkg::ST_OBS;
          end
        end
      end
      vlou_pkg::ST_OBS: begin
        state_d = vlou_pkg::ST_IDLE;
        if (r_tot == '0 && 32'(cnt_q) >= vlou_pkg::LIST_DEPTH) begin
          drop_d = 1'b1;
        end else begin
          g_we = 1'b1;
          if (r_tot == '0) begin
            l_we = 1'b1; cnt_d = cnt_q + 1'b1;
          end
        end
      end
      vlou_pkg::ST_WALK_RD: state_d = vlou_pkg::ST_WALK_CELL;
      vlou_pkg::ST_WALK_CELL: begin
        addr_d = (32'(l_rdata_q) >= vlou_pkg::CELLS) ? '0 : l_rdata_q;
        g_addr = addr_d;
        state_d = vlou_pkg::ST_WALK_OUT;
      end
      vlou_pkg::ST_WALK_OUT: begin
        if (out_free) begin
          g_we = 1'b1; g_wdata = {nv, {2*OW{1'b0}}};
          ov_d = 1'b1; o_addr_d = addr_q; o_val_d = nv; o_drop_d = drop_q;
          o_last_d = (32'(walk_q) + 1 == 32'(cnt_q));
          if (o_last_d) begin
            cnt_d = '0; drop_d = 1'b0; state_d = vlou_pkg::ST_IDLE;
          end else begin
            walk_d = walk_q + 1'b1; state_d = vlou_pkg::ST_WALK_RD;
          end
        end
      end
      default: state_d = vlou_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, o_val_q, o_addr_q};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_drop_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Voxel log-odds update unit: directed and random rays are fed in, and each
// emitted voxel update is checked against an in-bench grid predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 4 * int'(vlou_pkg::CELLS);

  typedef logic signed [vlou_pkg::VAL_W-1:0] val_t;

  typedef struct packed {
    logic [vlou_pkg::ADDR_W-1:0] addr;
    val_t                        value;
    logic                        last;
    logic                        dropped;
  } voxel_update_t;

  // grid predictor plus queue of expected voxel updates
  class voxel_update_board;
    val_t                       grid [int];
    logic [vlou_pkg::OBS_W-1:0] hits [int];
    logic [vlou_pkg::OBS_W-1:0] totals [int];
    int                         ray_list [$];
    bit                         drop_seen;
    val_t                       hit_inc, miss_inc, lower, upper;
    voxel_update_t              pending [$];
    int                         errors, updates_seen;

    function void set_reg(logic [1:0] idx, val_t v);
      case (idx)
        vlou_pkg::REG_HIT_INC:  hit_inc  = v;
        vlou_pkg::REG_MISS_INC: miss_inc = v;
        vlou_pkg::REG_LOWER:    lower    = v;
        vlou_pkg::REG_UPPER:    upper    = v;
        default: ;
      endcase
    endfunction

    function val_t next_value(int old, int inc);
      int v;
      if (inc >= 0 && old >= upper) return val_t'(old);
      if (inc <= 0 && old <= lower) return lower;
      v = old + inc;
      if (v < lower) v = lower;
      if (v > upper) v = upper;
      return val_t'(v);
    endfunction

    function void note_request(logic mode, int x, int y, int z, bit hit);
      int a, old, inc;
      voxel_update_t u;
      if (mode == vlou_pkg::MODE_OBSERVE) begin
        if (x >= vlou_pkg::GRID_X || y >= vlou_pkg::GRID_Y || z >= vlou_pkg::GRID_Z) begin
          drop_seen = 1;
          return;
        end
        a = x * vlou_pkg::GRID_Y * vlou_pkg::GRID_Z + y * vlou_pkg::GRID_Z + z;
        if (!totals.exists(a)) begin
          totals[a] = 0;
          hits[a] = 0;
        end
        if (totals[a] == 0) begin
          if (ray_list.size() >= vlou_pkg::LIST_DEPTH) begin
            drop_seen = 1;
            return;
          end
          ray_list = {ray_list, a};
        end
        if (totals[a] != vlou_pkg::COUNT_MAX) totals[a]++;
        if (hit && hits[a] != vlou_pkg::COUNT_MAX) hits[a]++;
        return;
      end
      foreach (ray_list[i]) begin
        a = ray_list[i];
        inc = (int'(totals[a]) >= 2 * int'(hits[a])) ? miss_inc : hit_inc;
        totals[a] = 0;
        hits[a] = 0;
        old = grid.exists(a) ? grid[a] : vlou_pkg::UNKNOWN_VALUE;
        grid[a] = next_value(old, inc);
        u.addr = a[vlou_pkg::ADDR_W-1:0];
        u.value = grid[a];
        u.last = (i == ray_list.size() - 1);
        u.dropped = drop_seen;
        pending = {pending, u};
      end
      ray_list.delete();
      drop_seen = 0;
    endfunction

    function void check_update(voxel_update_t got);
      voxel_update_t want;
      updates_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected update addr=%0d value=%0d", $time, got.addr, got.value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.addr !== want.addr)
        $display("%0t: addr exp=%0d got=%0d", $time, want.addr, got.addr);
      if (got.value !== want.value)
        $display("%0t: log_odds exp=%0d got=%0d", $time, want.value, got.value);
      if (got.last !== want.last)
        $display("%0t: last exp=%0b got=%0b", $time, want.last, got.last);
      if (got.dropped !== want.dropped)
        $display("%0t: dropped exp=%0b got=%0b", $time, want.dropped, got.dropped);
      if (got !== want) errors++;
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  voxel_update_board board = new();
  bit  calm;        // no idling in the last part
  bit  hold_off;    // request a long receiver hold-off
  bit  hold_done;   // hold-off already served
  int  quiet_cycles = 0;
  int  requests_sent, rays_sent;

  always #5 clk_i = ~clk_i;

  voxel_log_odds_update_unit DUT (.*);

  task automatic write_reg(logic [1:0] idx, val_t v);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    board.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_request(logic mode, int x, int y, int z, bit hit);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, hit, z[4:0], y[6:0], x[6:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(mode, x, y, z, hit);
    requests_sent++;
    if (mode == vlou_pkg::MODE_END_RAY) rays_sent++;
  endtask

  task automatic end_ray();
    send_request(vlou_pkg::MODE_END_RAY, int'($urandom_range(127)),
                 int'($urandom_range(127)), int'($urandom_range(31)),
                 bit'($urandom_range(1)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // voxels drawn from a small pool so rays revisit cells
  task automatic random_ray(int n_obs, int pool);
    int x, y, z;
    repeat (n_obs) begin
      x = int'($urandom_range(pool));
      y = int'($urandom_range(pool));
      z = int'($urandom_range(pool > 31 ? 31 : pool));
      if ($urandom_range(15) == 0) x = 127 - int'($urandom_range(3));
      send_request(vlou_pkg::MODE_OBSERVE, x, y, z, bit'($urandom_range(1)));
    end
    end_ray();
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_update('{m_axis_tdata[18:0], m_axis_tdata[30:19],
                           m_axis_tlast, m_axis_tuser});
  end

  initial begin : sink
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !hold_done) begin
        m_axis_tready <= 0;
        repeat (1000) @(posedge clk_i);
        hold_done = 1;
      end else if (!calm && $urandom_range(3) == 0) begin
        gap = $urandom_range(1, 4);
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stim
    board.set_reg(vlou_pkg::REG_HIT_INC, val_t'(158));
    board.set_reg(vlou_pkg::REG_MISS_INC, val_t'(-158));
    board.set_reg(vlou_pkg::REG_LOWER, val_t'(-510));
    board.set_reg(vlou_pkg::REG_UPPER, val_t'(562));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, duplicates, empty ray
    end_ray();
    send_request(vlou_pkg::MODE_OBSERVE, 0, 0, 0, 1'b1);
    send_request(vlou_pkg::MODE_OBSERVE, 127, 127, 31, 1'b0);
    send_request(vlou_pkg::MODE_OBSERVE, 0, 0, 0, 1'b0);
    send_request(vlou_pkg::MODE_OBSERVE, 85, 42, 21, 1'b1);
    send_request(vlou_pkg::MODE_OBSERVE, 42, 85, 10, 1'b0);
    end_ray();
    repeat (4) send_request(vlou_pkg::MODE_OBSERVE, 3, 3, 3, 1'b1);
    send_request(vlou_pkg::MODE_OBSERVE, 3, 3, 3, 1'b0);
    end_ray();
    drain();

    // extreme settings, inverted clamps
    write_reg(vlou_pkg::REG_HIT_INC, val_t'(2047));
    write_reg(vlou_pkg::REG_MISS_INC, val_t'(-2048));
    write_reg(vlou_pkg::REG_LOWER, val_t'(2047));
    write_reg(vlou_pkg::REG_UPPER, val_t'(-2048));
    send_request(vlou_pkg::MODE_OBSERVE, 1, 2, 3, 1'b1);
    send_request(vlou_pkg::MODE_OBSERVE, 4, 5, 6, 1'b0);
    end_ray();
    drain();
    write_reg(vlou_pkg::REG_LOWER, val_t'(-2048));
    write_reg(vlou_pkg::REG_UPPER, val_t'(2047));

    // full queue with overflow, receiver holding off while requests keep coming
    hold_off = 1;
    for (int i = 0; i < vlou_pkg::LIST_DEPTH + 3; i++)
      send_request(vlou_pkg::MODE_OBSERVE, i, 127 - i, i % 32, bit'(i % 2));
    end_ray();
    send_request(vlou_pkg::MODE_OBSERVE, 9, 9, 9, 1'b1);
    end_ray();
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        write_reg(vlou_pkg::REG_HIT_INC, val_t'(400));
        write_reg(vlou_pkg::REG_MISS_INC, val_t'(-100));
        write_reg(vlou_pkg::REG_LOWER, val_t'(-600));
        write_reg(vlou_pkg::REG_UPPER, val_t'(700));
      end
      if (phase == 2) begin
        write_reg(vlou_pkg::REG_HIT_INC, val_t'(-300));
        write_reg(vlou_pkg::REG_MISS_INC, val_t'(250));
        write_reg(vlou_pkg::REG_LOWER, val_t'(-1000));
        write_reg(vlou_pkg::REG_UPPER, val_t'(900));
        calm = 1;
      end
      repeat (6) random_ray($urandom_range(1, 10), 3);
      drain();
    end

    $display("tb_top: %0d requests in %0d rays, %0d voxel updates checked",
             requests_sent, rays_sent, board.updates_seen);
    $display("tb_top: covered clamps, inverted limits, queue overflow and output backpressure");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
